@@ rtl/tlae_pkg.sv @@
// Shared constants, types and codes for the two-level ANF evaluator.
package tlae_pkg;

   // Key, polynomial and table sizes
   localparam int KEY_BITS   = 80;
   localparam int POLY_COUNT = 64;
   localparam int MONO_DEPTH = 1024;
   localparam int LINE_DEPTH = 256;

   // Fixed field widths of the item layout
   localparam int LOW_W   = 64;
   localparam int HIGH_W  = 16;
   localparam int OWNER_W = 6;
   localparam int SEL_W   = 64;
   localparam int KEY_W   = LOW_W + HIGH_W;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 72;

   // Fill counts hold the depth itself; addresses hold depth - 1
   localparam int MONO_FW = $clog2(MONO_DEPTH + 1);
   localparam int LINE_FW = $clog2(LINE_DEPTH + 1);
   localparam int MONO_AW = (MONO_DEPTH > 1) ? $clog2(MONO_DEPTH) : 1;
   localparam int LINE_AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int FILL_W  = (MONO_FW > LINE_FW) ? MONO_FW : LINE_FW;

   // Key variables kept in the upper field
   localparam int HIGH_KEEP = ((KEY_BITS - LOW_W) >= HIGH_W) ? HIGH_W : (KEY_BITS - LOW_W);
   localparam logic [HIGH_W-1:0] HIGH_MASK =
      HIGH_W'((17'd1 << HIGH_KEEP) - 17'd1);
   localparam logic [SEL_W-1:0] POLY_RANGE =
      SEL_W'((65'd1 << POLY_COUNT) - 65'd1);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_MONO  = 2'd1,
      OP_LINE  = 2'd2,
      OP_EVAL  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DONE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MONO_RD,
      S_MONO_LAST,
      S_LINE_RD,
      S_LINE_LAST,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [HIGH_W-1:0]  high;
      logic [LOW_W-1:0]   low;
   } mono_word_type;

   // Sequencer to datapath controls
   typedef struct packed {
      logic              accept;
      logic              drop;
      logic              mono_we;
      logic              line_we;
      logic              mono_re;
      logic              line_re;
      logic [FILL_W-1:0] addr;
      logic              mono_chk;
      logic              line_chk;
      logic              eval_start;
      logic              eval_done;
   } ctl_type;

endpackage

@@ rtl/two_level_anf_evaluator.sv @@
// Top level of the two-level ANF evaluator: tables, shared subset compare, result register.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser opcode; tdata mask_low, mask_high,
//          |     |                        | poly_index, line_select
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser status; tdata value, poly_bits
//
// Clear and append items load their result into the output register at the accept
// edge. An evaluation walks the monomial table, then the line table, and loads its result
// once the output register is free: one monomial per cycle, then one line mask per
// cycle, through the single subset compare, each behind a registered table read.
// Reset (synchronous, active high) empties both tables and the output register; table
// contents are not cleared, since only entries below the fill counts are read.
// The input stalls while an evaluation runs and while an unread result blocks the
// output register; a new item is taken in the cycle the old result leaves.
module two_level_anf_evaluator
   import tlae_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] mask_low, [79:64] mask_high, [85:80] poly_index, [149:86] line_select
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] value, [64:1] poly_bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   ctl_type            ctl;
   op_type             req_op;
   logic [LOW_W-1:0]   in_low;
   logic [HIGH_W-1:0]  in_high;
   logic [OWNER_W-1:0] in_owner;
   logic [SEL_W-1:0]   in_sel;
   logic               rsp_free;

   mono_word_type      mono_wr, mono_rd;
   logic [SEL_W-1:0]   line_rd;

   logic [KEY_W-1:0]   key_ff;
   logic [SEL_W-1:0]   bits_ff, bits_in;
   logic               par_ff, par_in;

   logic [KEY_W-1:0]   cmp_mask, cmp_key;
   logic               cmp_hit;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_value_ff, rsp_value_in;
   logic [SEL_W-1:0]   rsp_bits_ff, rsp_bits_in;

   // Unpack the item; drop key variables beyond the key width
   assign req_op   = op_type'(req_tuser);
   assign in_low   = req_tdata[LOW_W-1:0];
   assign in_high  = req_tdata[KEY_W-1:LOW_W] & HIGH_MASK;
   assign in_owner = req_tdata[KEY_W+OWNER_W-1:KEY_W];
   assign in_sel   = req_tdata[KEY_W+OWNER_W+SEL_W-1:KEY_W+OWNER_W];

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   tlae_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .rsp_free   (rsp_free),
      .req_tready (req_tready),
      .ctl        (ctl)
   );

   assign mono_wr = '{owner: in_owner, high: in_high, low: in_low};

   tlae_ram #(
      .WIDTH ($bits(mono_word_type)),
      .DEPTH (MONO_DEPTH)
   ) u_mono_ram (
      .clock   (clock),
      .we      (ctl.mono_we),
      .addr    (ctl.addr[MONO_AW-1:0]),
      .wr_data (mono_wr),
      .rd_data (mono_rd)
   );

   tlae_ram #(
      .WIDTH (SEL_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .we      (ctl.line_we),
      .addr    (ctl.addr[LINE_AW-1:0]),
      .wr_data (in_sel),
      .rd_data (line_rd)
   );

   // Shared subset compare: every mask bit must also be set in the key.
   // Monomial phase tests against the key, line phase against the polynomial bits.
   always_comb begin
      if (ctl.mono_chk) begin
         cmp_mask = {mono_rd.high, mono_rd.low};
         cmp_key  = key_ff;
      end else begin
         cmp_mask = {{HIGH_W{1'b0}}, line_rd};
         cmp_key  = {{HIGH_W{1'b0}}, bits_ff & POLY_RANGE};
      end
      cmp_hit = (cmp_mask & ~cmp_key) == '0;
   end

   // Accumulate polynomial parities, then line parity
   always_comb begin
      bits_in = bits_ff;
      par_in  = par_ff;
      if (ctl.eval_start) begin
         bits_in = '0;
         par_in  = 1'b0;
      end else if (ctl.mono_chk) begin
         // Owners beyond the polynomial count never contribute
         if (cmp_hit && ({1'b0, mono_rd.owner} < (OWNER_W+1)'(POLY_COUNT))) begin
            bits_in = bits_ff ^ (SEL_W'(1) << mono_rd.owner);
         end
      end else if (ctl.line_chk) begin
         if (cmp_hit) begin
            par_in = ~par_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.eval_start) begin
         key_ff <= {in_high, in_low};
      end
      bits_ff <= bits_in;
      par_ff  <= par_in;
   end

   // Output register: load an immediate status on accept, the evaluation at its end
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_bits_in   = rsp_bits_ff;
      if (ctl.accept && !ctl.eval_start) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ctl.drop ? ST_FULL : ST_OK;
         rsp_value_in  = 1'b0;
         rsp_bits_in   = '0;
      end else if (ctl.eval_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_DONE;
         rsp_value_in  = par_ff;
         rsp_bits_in   = bits_ff & POLY_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_bits_ff   <= rsp_bits_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SEL_W-1){1'b0}}, rsp_bits_ff, rsp_value_ff};

   // A result is loaded only into a free output register
   assert property (@(posedge clock) disable iff (reset)
      (ctl.eval_done || (ctl.accept && !ctl.eval_start)) |-> rsp_free)
      else $error("result loaded over an unread result");

   // Polynomial bits stay inside the polynomial range
   assert property (@(posedge clock) disable iff (reset)
      (bits_ff & ~POLY_RANGE) == '0)
      else $error("polynomial bit beyond polynomial count");

   // A finished evaluation is presented with the done status next cycle
   assert property (@(posedge clock) disable iff (reset)
      ctl.eval_done |=> rsp_tvalid && (rsp_tuser == ST_DONE))
      else $error("evaluation result not presented");

endmodule

@@ rtl/tlae_ram.sv @@
// Single-port table memory with registered read data.
module tlae_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tlae_seq.sv @@
// Sequencer: table fill counts, walk counter and evaluation phases.
module tlae_seq
   import tlae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  op_type  req_op,
   input  logic    rsp_free,
   output logic    req_tready,
   output ctl_type ctl
);

   state_type         state_ff, state_in;
   logic [MONO_FW-1:0] mono_fill_ff, mono_fill_in;
   logic [LINE_FW-1:0] line_fill_ff, line_fill_in;
   logic [FILL_W-1:0]  cnt_ff, cnt_in;
   logic               mono_chk_ff, line_chk_ff;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mono_fill_ff <= '0;
         line_fill_ff <= '0;
         cnt_ff       <= '0;
         mono_chk_ff  <= 1'b0;
         line_chk_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mono_fill_ff <= mono_fill_in;
         line_fill_ff <= line_fill_in;
         cnt_ff       <= cnt_in;
         mono_chk_ff  <= ctl.mono_re;
         line_chk_ff  <= ctl.line_re;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      mono_fill_in   = mono_fill_ff;
      line_fill_in   = line_fill_ff;
      cnt_in         = cnt_ff;
      ctl            = '0;
      ctl.accept     = accept;
      ctl.mono_chk   = mono_chk_ff;
      ctl.line_chk   = line_chk_ff;
      ctl.addr       = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_CLEAR: begin
                     mono_fill_in = '0;
                     line_fill_in = '0;
                  end
                  OP_MONO: begin
                     ctl.addr = FILL_W'(mono_fill_ff);
                     if (mono_fill_ff == MONO_FW'(MONO_DEPTH)) begin
                        ctl.drop = 1'b1;
                     end else begin
                        ctl.mono_we  = 1'b1;
                        mono_fill_in = mono_fill_ff + MONO_FW'(1);
                     end
                  end
                  OP_LINE: begin
                     ctl.addr = FILL_W'(line_fill_ff);
                     if (line_fill_ff == LINE_FW'(LINE_DEPTH)) begin
                        ctl.drop = 1'b1;
                     end else begin
                        ctl.line_we  = 1'b1;
                        line_fill_in = line_fill_ff + LINE_FW'(1);
                     end
                  end
                  OP_EVAL: begin
                     ctl.eval_start = 1'b1;
                     cnt_in         = '0;
                     if (mono_fill_ff != '0) begin
                        state_in = S_MONO_RD;
                     end else if (line_fill_ff != '0) begin
                        state_in = S_LINE_RD;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_MONO_RD: begin
            ctl.mono_re = 1'b1;
            if ((cnt_ff + FILL_W'(1)) == FILL_W'(mono_fill_ff)) begin
               cnt_in   = '0;
               state_in = S_MONO_LAST;
            end else begin
               cnt_in = cnt_ff + FILL_W'(1);
            end
         end
         S_MONO_LAST: begin
            // last monomial compare lands here; polynomial bits settle after it
            if (line_fill_ff != '0) begin
               state_in = S_LINE_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LINE_RD: begin
            ctl.line_re = 1'b1;
            if ((cnt_ff + FILL_W'(1)) == FILL_W'(line_fill_ff)) begin
               cnt_in   = '0;
               state_in = S_LINE_LAST;
            end else begin
               cnt_in = cnt_ff + FILL_W'(1);
            end
         end
         S_LINE_LAST: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               ctl.eval_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Fill counts never pass the table depth
   assert property (@(posedge clock) disable iff (reset)
      (mono_fill_ff <= MONO_FW'(MONO_DEPTH)) && (line_fill_ff <= LINE_FW'(LINE_DEPTH)))
      else $error("fill count beyond table depth");

   // Walk reads only written monomial entries
   assert property (@(posedge clock) disable iff (reset)
      ctl.mono_re |-> (cnt_ff < FILL_W'(mono_fill_ff)))
      else $error("monomial read beyond fill");

   // Walk reads only written line entries
   assert property (@(posedge clock) disable iff (reset)
      ctl.line_re |-> (cnt_ff < FILL_W'(line_fill_ff)))
      else $error("line read beyond fill");

   // An accepted evaluation leaves idle and holds off the input
   assert property (@(posedge clock) disable iff (reset)
      ctl.eval_start |=> (state_ff != S_IDLE) && !req_tready)
      else $error("evaluation did not start");

   // Compare strobes of both phases never overlap
   assert property (@(posedge clock) disable iff (reset)
      !(mono_chk_ff && line_chk_ff))
      else $error("monomial and line compares overlap");

endmodule

@@ tb/anf_tb_pkg.sv @@
// Expected-result tracking and prediction for the two-level ANF evaluator bench.
package anf_tb_pkg;
   import tlae_pkg::*;

   typedef struct packed {
      status_type       status;
      logic             value;
      logic [SEL_W-1:0] poly_bits;
   } anf_result_type;

   class anf_scoreboard;
      logic [LOW_W-1:0]   mono_low   [MONO_DEPTH];
      logic [HIGH_W-1:0]  mono_high  [MONO_DEPTH];
      logic [OWNER_W-1:0] mono_owner [MONO_DEPTH];
      logic [SEL_W-1:0]   line_mask  [LINE_DEPTH];
      int unsigned        mono_count;
      int unsigned        line_count;
      logic [HIGH_W-1:0]  high_keep;
      logic [SEL_W-1:0]   poly_keep;
      anf_result_type     expected_results[$];
      int                 mismatch_count;
      int                 request_count;
      int                 eval_count;
      int                 drop_count;

      function new();
         mono_count     = 0;
         line_count     = 0;
         mismatch_count = 0;
         request_count  = 0;
         eval_count     = 0;
         drop_count     = 0;
         // key variables past KEY_BITS and polynomials past POLY_COUNT drop out
         for (int b = 0; b < HIGH_W; b++) high_keep[b] = (LOW_W + b < KEY_BITS);
         for (int j = 0; j < SEL_W; j++) poly_keep[j] = (j < POLY_COUNT);
      endfunction

      function anf_result_type evaluate_key(logic [LOW_W-1:0] key_low,
                                            logic [HIGH_W-1:0] key_high);
         anf_result_type r;
         logic           parity;
         r.status    = ST_DONE;
         r.poly_bits = '0;
         parity      = 1'b0;
         for (int i = 0; i < mono_count; i++) begin
            if ((mono_low[i] & key_low) == mono_low[i] &&
                (mono_high[i] & key_high) == mono_high[i] &&
                mono_owner[i] < POLY_COUNT)
               r.poly_bits[mono_owner[i]] = ~r.poly_bits[mono_owner[i]];
         end
         r.poly_bits &= poly_keep;
         for (int i = 0; i < line_count; i++) begin
            if ((line_mask[i] & r.poly_bits) == line_mask[i]) parity = ~parity;
         end
         r.value = parity;
         return r;
      endfunction

      function void note_request(op_type op, logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi,
                                 logic [OWNER_W-1:0] owner, logic [SEL_W-1:0] sel);
         anf_result_type r;
         r.status    = ST_OK;
         r.value     = 1'b0;
         r.poly_bits = '0;
         request_count++;
         case (op)
            OP_CLEAR: begin
               mono_count = 0;
               line_count = 0;
            end
            OP_MONO: begin
               if (mono_count >= MONO_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  mono_low[mono_count]   = lo;
                  mono_high[mono_count]  = hi & high_keep;
                  mono_owner[mono_count] = owner;
                  mono_count++;
               end
            end
            OP_LINE: begin
               if (line_count >= LINE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  line_mask[line_count] = sel;
                  line_count++;
               end
            end
            OP_EVAL: begin
               r = evaluate_key(lo, hi & high_keep);
               eval_count++;
            end
         endcase
         if (r.status == ST_FULL) drop_count++;
         expected_results.push_back(r);
      endfunction

      function void flag_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, what);
      endfunction

      function void check_response(logic [1:0] status, logic value, logic [SEL_W-1:0] bits);
         anf_result_type want;
         if (expected_results.size() == 0) begin
            flag_mismatch($sformatf("result with nothing pending: status %0d value %0d bits %h",
                                    status, value, bits));
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status || value !== want.value || bits !== want.poly_bits)
            flag_mismatch($sformatf(
               "expected status %0d value %0d bits %h, got status %0d value %0d bits %h",
               want.status, want.value, want.poly_bits, status, value, bits));
      endfunction

      function int pending_count();
         return expected_results.size();
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// Stream-level testbench for the two-level ANF evaluator with a predicting scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tlae_pkg::*;
   import anf_tb_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [63:0] mask_low, [79:64] mask_high, [85:80] poly_index, [149:86] line_select
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [1:0] opcode
   logic [1:0]            req_tuser  = OP_CLEAR;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] value, [64:1] poly_bits
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [1:0]            rsp_tuser;

   // idle percentages of sender and receiver, changed per phase
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   anf_scoreboard tracker = new();

   two_level_anf_evaluator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random; the rate follows the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watch both channels at the edge. Check the outgoing item first: anything accepted
   // at this edge can only answer an item taken at an earlier edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_response(rsp_tuser, rsp_tdata[0], rsp_tdata[SEL_W:1]);
         if (req_tvalid && req_tready)
            tracker.note_request(op_type'(req_tuser),
                                 req_tdata[LOW_W-1:0],
                                 req_tdata[KEY_W-1:LOW_W],
                                 req_tdata[KEY_W+OWNER_W-1:KEY_W],
                                 req_tdata[KEY_W+OWNER_W+SEL_W-1:KEY_W+OWNER_W]);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return {16'($urandom), rand64()};
   endfunction

   // Mostly subsets of the episode's base key, so that evaluations actually hit monomials.
   function automatic logic [KEY_W-1:0] pick_monomial(logic [KEY_W-1:0] base);
      logic [KEY_W-1:0] m;
      case ($urandom_range(0, 5))
         0:       m = '0;
         1:       m = base & rand_key() & rand_key() & rand_key();
         2, 3:    m = base & rand_key() & rand_key();
         4:       m = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
         default: m = rand_key();
      endcase
      return m;
   endfunction

   // Favor the low polynomials, where most monomials land.
   function automatic logic [OWNER_W-1:0] pick_owner();
      if ($urandom_range(0, 3) != 0) return OWNER_W'($urandom_range(0, 7));
      return OWNER_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [SEL_W-1:0] pick_line();
      logic [SEL_W-1:0] s;
      case ($urandom_range(0, 5))
         0:       s = '0;
         1, 2:    s = SEL_W'($urandom_range(0, 255)) & SEL_W'($urandom_range(0, 255));
         3:       s = SEL_W'(1) << $urandom_range(0, 7);
         4:       s = rand64();
         default: s = SEL_W'(1) << $urandom_range(0, SEL_W - 1);
      endcase
      return s;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(logic [KEY_W-1:0] base);
      logic [KEY_W-1:0] k;
      case ($urandom_range(0, 5))
         0, 1:    k = base;
         2:       k = base & ~(KEY_W'(1) << $urandom_range(0, KEY_W - 1));
         3:       k = '1;
         4:       k = rand_key();
         default: k = base | rand_key();
      endcase
      return k;
   endfunction

   // Offer one item, idling first at the sender's rate, and hold it until taken.
   // Leave tvalid high on return so back-to-back items need no extra assignment.
   task automatic send_item(op_type op, logic [LOW_W-1:0] lo, logic [HIGH_W-1:0] hi,
                            logic [OWNER_W-1:0] owner, logic [SEL_W-1:0] sel);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({sel, owner, hi, lo});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Fields an operation ignores get random values so that their bits still toggle.
   task automatic clear_tables();
      send_item(OP_CLEAR, rand64(), 16'($urandom), OWNER_W'($urandom), rand64());
   endtask

   task automatic append_monomial(logic [KEY_W-1:0] mask, logic [OWNER_W-1:0] owner);
      send_item(OP_MONO, mask[LOW_W-1:0], mask[KEY_W-1:LOW_W], owner, rand64());
   endtask

   task automatic append_line(logic [SEL_W-1:0] sel);
      send_item(OP_LINE, rand64(), 16'($urandom), OWNER_W'($urandom), sel);
   endtask

   task automatic evaluate(logic [KEY_W-1:0] key);
      send_item(OP_EVAL, key[LOW_W-1:0], key[KEY_W-1:LOW_W], OWNER_W'($urandom), rand64());
   endtask

   task automatic wait_for_results();
      while (tracker.pending_count() != 0) @(posedge clock);
   endtask

   // Random episodes: mostly a table build-up followed by a few evaluations against a
   // shared base key, sometimes stacked on the previous tables, the rest plain noise.
   task automatic run_random(int item_goal);
      int               start;
      logic [KEY_W-1:0] base;
      start = tracker.request_count;
      while (tracker.request_count - start < item_goal) begin
         if ($urandom_range(99) < 85) begin
            base = rand_key() | rand_key();
            if ($urandom_range(99) < 70) clear_tables();
            repeat ($urandom_range(0, 12)) append_monomial(pick_monomial(base), pick_owner());
            repeat ($urandom_range(0, 6)) append_line(pick_line());
            repeat ($urandom_range(1, 4)) evaluate(pick_key(base));
         end else begin
            send_item(op_type'($urandom_range(0, 3)), rand64(), 16'($urandom),
                      OWNER_W'($urandom), rand64());
         end
      end
   endtask

   initial begin
      logic [KEY_W-1:0] base;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Phase one: light sender gaps, heavy receiver stalls.
      req_idle_pct = 11;
      rsp_idle_pct = 63;

      // Directed: empty tables, constant-one masks, extremes of key and masks.
      evaluate('0);
      evaluate('1);
      append_line('0);                           // empty line counts as satisfied
      evaluate('0);
      append_monomial('0, OWNER_W'(0));          // empty monomial: poly 0 constant one
      append_monomial('1, OWNER_W'(63));         // needs every key variable
      append_monomial(KEY_W'(1) << (KEY_W - 1), OWNER_W'(5));  // top key variable only
      append_monomial(KEY_W'(1), OWNER_W'(0));
      append_line('1);                           // needs every polynomial bit
      append_line(64'h8000_0000_0000_0001);
      append_line(64'h20);
      evaluate('1);
      evaluate('0);
      evaluate(KEY_W'(1) << (KEY_W - 1));
      evaluate(KEY_W'(1));
      append_monomial('0, OWNER_W'(0));          // second constant cancels the first
      evaluate('1);
      clear_tables();
      evaluate('1);                              // tables empty again after clear
      append_monomial({16'h0001, 64'h8000_0000_0000_0000}, OWNER_W'(33));
      append_line(SEL_W'(1) << 33);
      evaluate({16'h0001, 64'h8000_0000_0000_0000});
      evaluate({16'h0000, 64'h8000_0000_0000_0000});

      // Fill the line table to capacity, push past the end, evaluate with it full.
      base = rand_key() | rand_key();
      clear_tables();
      repeat (LINE_DEPTH) append_line(pick_line());
      repeat (2) append_line(pick_line());       // dropped: line table full
      repeat (24) append_monomial(pick_monomial(base), pick_owner());
      repeat (3) evaluate(pick_key(base));
      evaluate('1);
      clear_tables();

      run_random(30);
      req_tvalid <= 1'b0;
      wait_for_results();

      // Phase two: swap the idle rates.
      req_idle_pct = 63;
      rsp_idle_pct = 11;
      run_random(30);
      req_tvalid <= 1'b0;
      wait_for_results();

      // Phase three: full throughput on both sides.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(30);

      req_tvalid <= 1'b0;
      wait_for_results();
      // give a late or duplicate item time to show up
      repeat (MONO_DEPTH + LINE_DEPTH + 8) @(posedge clock);

      $display("Run covered %0d items, %0d evaluations, %0d appends dropped on full tables.",
               tracker.request_count, tracker.eval_count, tracker.drop_count);
      $display("Mismatches: %0d, results still pending: %0d.",
               tracker.mismatch_count, tracker.pending_count());
      if (tracker.mismatch_count == 0 && tracker.pending_count() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Stop a hung run; well above the slowest legal run with every stall.
   initial begin
      #(5_000_000);
      $display("Timeout with %0d results pending.", tracker.pending_count());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
